### design/lmp_pkg.sv
package lmp_pkg;

	// Drive along offset_y when set, along offset_x when clear.
	localparam logic DRIVE_AXIS_Y = 1'b0;

	localparam int unsigned REG_WIDTH = 31;
	localparam int unsigned REG_INDEX_WIDTH = 3;

	typedef enum logic [REG_INDEX_WIDTH-1:0] {
		REG_MIN_SPEED        = 3'd0,
		REG_MAX_SPEED        = 3'd1,
		REG_ACCELERATION     = 3'd2,
		REG_ARRIVE_TOLERANCE = 3'd3,
		REG_GAIN_P           = 3'd4,
		REG_GAIN_I           = 3'd5,
		REG_GAIN_D           = 3'd6,
		REG_LATERAL_LIMIT    = 3'd7
	} cfg_reg_t;

	localparam logic [REG_WIDTH-1:0] RST_MIN_SPEED        = 31'd19661;
	localparam logic [REG_WIDTH-1:0] RST_MAX_SPEED        = 31'd32768;
	localparam logic [REG_WIDTH-1:0] RST_ACCELERATION     = 31'd32768;
	localparam logic [REG_WIDTH-1:0] RST_ARRIVE_TOLERANCE = 31'd3277;
	localparam logic [REG_WIDTH-1:0] RST_GAIN_P           = 31'd0;
	localparam logic [REG_WIDTH-1:0] RST_GAIN_I           = 31'd0;
	localparam logic [REG_WIDTH-1:0] RST_GAIN_D           = 31'd196608;
	localparam logic [REG_WIDTH-1:0] RST_LATERAL_LIMIT    = 31'd32768;

	typedef enum logic [1:0] {
		TERM_P = 2'd0,
		TERM_I = 2'd1,
		TERM_D = 2'd2
	} term_t;

	localparam logic [1:0] STATUS_MOVING    = 2'd0;
	localparam logic [1:0] STATUS_ARRIVED   = 2'd1;
	localparam logic [1:0] STATUS_PREEMPTED = 2'd2;

	// Gain term magnitude bound, 2^52.
	localparam logic [63:0] TERM_SAT = 64'h0010_0000_0000_0000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_T_HI,
		S_T_LO,
		S_T_MAG,
		S_T_SUM,
		S_CLAMP,
		S_MUL_A,
		S_SQ_LOAD,
		S_SQRT,
		S_FIN
	} seq_state_t;

endpackage

### design/linear_move_profile_with_lateral_pid_core.sv
// Linear move controller core. Each accepted item is one control tick: goal offset in the
// robot frame and forward clearance in Q16.16, a preempt flag and a forced-stop flag. The
// core runs a lateral PID on offset_y (saturating 48-bit integral, output clamped to
// +-lateral_limit) and a square-root speed profile along the drive axis, and returns one
// result item per tick: speed_command, lateral_rate and status (moving, arrived,
// preempted). Each item runs three gain terms, each through S_T_HI, S_T_LO, S_T_MAG and
// S_T_SUM on a single shared 32x32 multiplier, then a clamp, the acceleration-times-distance
// product on the same multiplier, and a 32-step bit-serial square root. in_stall is high
// for the whole computation. The finished result waits in an output register, so the next
// item is taken while it is still unclaimed; only a result that finds that register full and
// stalled holds the core. The user must write configuration registers through
// cfg_write_en/cfg_index/cfg_data only while the core is idle, which the core does not
// enforce; they take effect on the next item.
module linear_move_profile_with_lateral_pid_core (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_write_en,
	input  logic [lmp_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [lmp_pkg::REG_WIDTH-1:0]       cfg_data,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                goal_start,
	input  logic signed [31:0]                  offset_x,
	input  logic signed [31:0]                  offset_y,
	input  logic [30:0]                         clearance,
	input  logic                                preempt,
	input  logic                                force_stop,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [31:0]                  speed_command,
	output logic signed [31:0]                  lateral_rate,
	output logic [1:0]                          status
);
	import lmp_pkg::*;

	// Configuration registers.
	logic [REG_WIDTH-1:0] min_speed_q, max_speed_q, accel_q, arrive_tol_q;
	logic [REG_WIDTH-1:0] gain_p_q, gain_i_q, gain_d_q, lat_limit_q;

	// PID history.
	logic signed [31:0] prev_err_q;
	logic signed [47:0] integ_q;

	// Per-item working registers.
	logic signed [32:0] diff_q;
	logic               neg_q;
	logic [31:0]        dist_q;
	logic [30:0]        clear_q;
	logic               preempt_q;
	logic               stop_q;
	term_t              term_q;
	logic [63:0]        prod_q;
	logic [62:0]        hi_q;
	logic [52:0]        mag_q;
	logic signed [54:0] sum_q;
	logic signed [31:0] rot_q;
	logic [63:0]        rem_q;
	logic [63:0]        root_q;
	logic [63:0]        bit_q;
	logic [4:0]         cnt_q;

	// Output register.
	logic               out_valid_q;
	logic signed [31:0] speed_q;
	logic signed [31:0] lat_q;
	logic [1:0]         status_q;

	seq_state_t state_q, state_d;
	logic       in_accept;
	logic       out_free;
	logic       out_load;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_accept = in_valid && !in_stall;

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = S_T_HI;
				end
			end
			S_T_HI:  state_d = S_T_LO;
			S_T_LO:  state_d = S_T_MAG;
			S_T_MAG: state_d = S_T_SUM;
			S_T_SUM: begin
				// advance to the next gain term, or clamp after the derivative term
				state_d = (term_q == TERM_D) ? S_CLAMP : S_T_HI;
			end
			S_CLAMP:   state_d = S_MUL_A;
			S_MUL_A:   state_d = S_SQ_LOAD;
			S_SQ_LOAD: state_d = S_SQRT;
			S_SQRT: begin
				if (cnt_q == 5'd0) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				// hold the result until the output register is free
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q  <= RST_MIN_SPEED;
			max_speed_q  <= RST_MAX_SPEED;
			accel_q      <= RST_ACCELERATION;
			arrive_tol_q <= RST_ARRIVE_TOLERANCE;
			gain_p_q     <= RST_GAIN_P;
			gain_i_q     <= RST_GAIN_I;
			gain_d_q     <= RST_GAIN_D;
			lat_limit_q  <= RST_LATERAL_LIMIT;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_SPEED:        min_speed_q  <= cfg_data;
				REG_MAX_SPEED:        max_speed_q  <= cfg_data;
				REG_ACCELERATION:     accel_q      <= cfg_data;
				REG_ARRIVE_TOLERANCE: arrive_tol_q <= cfg_data;
				REG_GAIN_P:           gain_p_q     <= cfg_data;
				REG_GAIN_I:           gain_i_q     <= cfg_data;
				REG_GAIN_D:           gain_d_q     <= cfg_data;
				REG_LATERAL_LIMIT:    lat_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- tick intake
	// A new move starts from empty PID history.
	logic signed [31:0] base_prev;
	logic signed [47:0] base_integ;
	logic signed [48:0] integ_sum;
	logic signed [47:0] integ_sat;
	logic signed [31:0] axis_val;
	logic signed [32:0] axis_neg;

	always_comb begin
		base_prev  = goal_start ? 32'sd0 : prev_err_q;
		base_integ = goal_start ? 48'sd0 : integ_q;
		integ_sum  = 49'(base_integ) + 49'(offset_y);
		// saturate at the 48-bit signed range
		if (integ_sum[48] != integ_sum[47]) begin
			integ_sat = integ_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			integ_sat = integ_sum[47:0];
		end
		axis_val = DRIVE_AXIS_Y ? offset_y : offset_x;
		axis_neg = -33'(axis_val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
		end else if (in_accept) begin
			// PID state advances on every tick, whatever the outcome
			prev_err_q <= offset_y;
			integ_q    <= integ_sat;
		end
	end

	// ---------------------------------------------------------------- shared multiplier
	logic signed [47:0] term_val;
	logic [30:0]        term_gain;
	logic               term_neg;
	logic [47:0]        term_mag;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;
	logic [31:0]        near;

	always_comb begin
		unique case (term_q)
			TERM_P: begin
				term_val  = 48'(prev_err_q);
				term_gain = gain_p_q;
			end
			TERM_I: begin
				term_val  = integ_q;
				term_gain = gain_i_q;
			end
			TERM_D: begin
				term_val  = 48'(diff_q);
				term_gain = gain_d_q;
			end
			default: begin
				term_val  = '0;
				term_gain = '0;
			end
		endcase
		term_neg = term_val[47];
		term_mag = term_neg ? 48'(-term_val) : 48'(term_val);
		near     = (32'(clear_q) < dist_q) ? 32'(clear_q) : dist_q;

		unique case (state_q)
			S_T_HI: begin
				mul_a = 32'(term_gain);
				mul_b = term_mag[47:16];
			end
			S_T_LO: begin
				mul_a = 32'(term_gain);
				mul_b = 32'(term_mag[15:0]);
			end
			S_MUL_A: begin
				mul_a = 32'(accel_q);
				mul_b = near;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = 64'(mul_a) * 64'(mul_b);
	end

	// ---------------------------------------------------------------- datapath
	logic [47:0]        lo_round;
	logic [63:0]        mag_full;
	logic signed [54:0] mag_ext;
	logic signed [54:0] lim_ext;
	logic [63:0]        sq_trial;
	logic [31:0]        vel;
	logic [31:0]        root_lo;

	always_comb begin
		// floor for negative values: bias the low product before the shift
		lo_round = prod_q[47:0] + (term_neg ? 48'h00_0000_FFFF : 48'd0);
		mag_full = 64'(hi_q) + 64'(lo_round[47:16]);
		mag_ext  = 55'(mag_q);
		lim_ext  = 55'(lat_limit_q);
		sq_trial = root_q + bit_q;

		root_lo = root_q[31:0];
		vel     = 32'(clear_q);
		if (32'(dist_q[31:1]) < vel) begin
			vel = 32'(dist_q[31:1]);
		end
		if (32'(max_speed_q) < vel) begin
			vel = 32'(max_speed_q);
		end
		if (root_lo < vel) begin
			vel = root_lo;
		end
		if (vel < 32'(min_speed_q)) begin
			vel = 32'(min_speed_q);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					diff_q    <= 33'(offset_y) - 33'(base_prev);
					neg_q     <= axis_val[31];
					dist_q    <= axis_val[31] ? axis_neg[31:0] : 32'(axis_val);
					clear_q   <= clearance;
					preempt_q <= preempt;
					stop_q    <= force_stop;
					term_q    <= TERM_P;
					sum_q     <= '0;
				end
			end
			S_T_HI: begin
				prod_q <= mul_p;
			end
			S_T_LO: begin
				hi_q   <= prod_q[62:0];
				prod_q <= mul_p;
			end
			S_T_MAG: begin
				mag_q <= (mag_full > TERM_SAT) ? TERM_SAT[52:0] : mag_full[52:0];
			end
			S_T_SUM: begin
				sum_q  <= sum_q + (term_neg ? -mag_ext : mag_ext);
				term_q <= term_t'(term_q + 2'd1);
			end
			S_CLAMP: begin
				if (sum_q > lim_ext) begin
					rot_q <= lim_ext[31:0];
				end else if (sum_q < -lim_ext) begin
					rot_q <= 32'(-lim_ext);
				end else begin
					rot_q <= sum_q[31:0];
				end
			end
			S_MUL_A: begin
				prod_q <= mul_p;
			end
			S_SQ_LOAD: begin
				rem_q  <= {prod_q[62:0], 1'b0};
				root_q <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
				cnt_q  <= 5'd31;
			end
			S_SQRT: begin
				// one restoring square-root step per cycle
				if (rem_q >= sq_trial) begin
					rem_q  <= rem_q - sq_trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 5'd1;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			// preempt wins over arrival; force stop zeroes both commands
			if (preempt_q) begin
				status_q <= STATUS_PREEMPTED;
				speed_q  <= '0;
				lat_q    <= '0;
			end else if (dist_q < 32'(arrive_tol_q)) begin
				status_q <= STATUS_ARRIVED;
				speed_q  <= '0;
				lat_q    <= stop_q ? 32'sd0 : rot_q;
			end else begin
				status_q <= STATUS_MOVING;
				speed_q  <= stop_q ? 32'sd0 : (neg_q ? -vel : vel);
				lat_q    <= stop_q ? 32'sd0 : rot_q;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign speed_command = speed_q;
	assign lateral_rate  = lat_q;
	assign status        = status_q;

endmodule
